[hdl/rot_enc_pkg.sv]
// ----------------------------------------------------------------------------
// rot_enc_pkg - shared types and constants for the rotary encoder block
// Event codes, the queued event record and the quadrature step table.
// ----------------------------------------------------------------------------
package rot_enc_pkg;

    // event codes
    localparam logic [1:0] EVT_CW    = 2'd0;
    localparam logic [1:0] EVT_CCW   = 2'd1;
    localparam logic [1:0] EVT_PRESS = 2'd2;

    // item kinds
    localparam logic KIND_PIN  = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // reset values
    localparam logic [1:0]  AB_IDLE          = 2'b11;
    localparam logic [15:0] DEBOUNCE_DEFAULT = 16'd50;

    // detent thresholds
    localparam logic signed [7:0] DETENT_POS = 8'sd4;
    localparam logic signed [7:0] DETENT_NEG = -8'sd4;

    // one queued result beat
    typedef struct packed {
        logic [1:0]  code;
        logic [31:0] time_ms;
        logic        last;
    } event_t;

    // quadrature step for {previous_ab, new_ab}
    function automatic logic signed [7:0] quad_step(input logic [3:0] idx);
        logic signed [7:0] step;
        begin
            case (idx)
                4'd1, 4'd7, 4'd8, 4'd14: step = -8'sd1;
                4'd2, 4'd4, 4'd11, 4'd13: step = 8'sd1;
                default: step = 8'sd0;
            endcase
            return step;
        end
    endfunction

endpackage

[hdl/rotary_encoder_detent_and_button.sv]
// A poll beat's result passes through the input register, then the event
// queue register, before it appears as a result beat.
// Throughput: one input beat per cycle; one output event per cycle while
// out_stall is low; input stalls when the four-entry queue cannot take two.
// Reset: accumulator 0, A/B pair idle high, button released, timestamp 0,
// debounce time 50 ms, queue empty.
// ----------------------------------------------------------------------------
// rotary_encoder_detent_and_button - quadrature decoder with button debounce
// Counts encoder steps from pin samples and, on each poll, emits detent and
// debounced button press events through a small event queue.
// ----------------------------------------------------------------------------
module rotary_encoder_detent_and_button
    import rot_enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic        enc_a,
    input  logic        enc_b,
    input  logic        button_level,
    input  logic [31:0] now_ms,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_code,
    output logic [31:0] event_time,
    output logic        last
);

    localparam int QDEPTH = 4;

    // configuration and decoder state
    logic [15:0]       debounce_reg;
    logic signed [7:0] acc_reg, acc_next;
    logic [1:0]        prev_ab_reg, prev_ab_next;
    logic              stable_btn_reg, stable_btn_next;
    logic [31:0]       btn_ts_reg, btn_ts_next;

    // input register
    logic        in_valid_reg;
    logic        kind_reg;
    logic        enc_a_reg;
    logic        enc_b_reg;
    logic        button_reg;
    logic [31:0] now_reg;

    // event queue
    event_t      queue_reg [QDEPTH];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg, count_next;

    logic        proc_fire;
    logic        in_accept;
    logic        pop;
    logic        detent_hit;
    logic        press_hit;
    logic [1:0]  push_n;
    event_t      ev0, ev1;
    logic signed [7:0] acc_neg;
    logic signed [7:0] acc_rem;
    logic [31:0] elapsed;

    // handshake
    assign proc_fire = in_valid_reg && (count_reg <= 3'(QDEPTH - 2));
    assign in_stall  = in_valid_reg && !proc_fire;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && !out_stall;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_reg <= DEBOUNCE_DEFAULT;
        else if (cfg_wr_en)
            debounce_reg <= cfg_wr_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_valid_reg || proc_fire)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg   <= kind;
            enc_a_reg  <= enc_a;
            enc_b_reg  <= enc_b;
            button_reg <= button_level;
            now_reg    <= now_ms;
        end
    end

    // decode and debounce
    always_comb
    begin
        acc_next        = acc_reg;
        prev_ab_next    = prev_ab_reg;
        stable_btn_next = stable_btn_reg;
        btn_ts_next     = btn_ts_reg;
        detent_hit      = 1'b0;
        press_hit       = 1'b0;
        acc_neg         = -acc_reg;
        acc_rem         = acc_reg[7] ? -(acc_neg & 8'sd3) : (acc_reg & 8'sd3);
        elapsed         = now_reg - btn_ts_reg;

        if (proc_fire)
        begin
            if (kind_reg == KIND_PIN)
            begin
                acc_next     = acc_reg + quad_step({prev_ab_reg, enc_a_reg, enc_b_reg});
                prev_ab_next = {enc_a_reg, enc_b_reg};
            end
            else
            begin
                if (acc_reg >= DETENT_POS || acc_reg <= DETENT_NEG)
                begin
                    detent_hit = 1'b1;
                    acc_next   = acc_rem;
                end
                if (button_reg != stable_btn_reg)
                begin
                    if (elapsed > {16'd0, debounce_reg})
                    begin
                        stable_btn_next = button_reg;
                        btn_ts_next     = now_reg;
                        press_hit       = !button_reg;
                    end
                end
                else
                begin
                    btn_ts_next = now_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= 8'sd0;
            prev_ab_reg    <= AB_IDLE;
            stable_btn_reg <= 1'b1;
            btn_ts_reg     <= 32'd0;
        end
        else
        begin
            acc_reg        <= acc_next;
            prev_ab_reg    <= prev_ab_next;
            stable_btn_reg <= stable_btn_next;
            btn_ts_reg     <= btn_ts_next;
        end
    end

    // events to push, detent before press
    always_comb
    begin
        ev0.code    = detent_hit ? (acc_reg[7] ? EVT_CCW : EVT_CW) : EVT_PRESS;
        ev0.time_ms = now_reg;
        ev0.last    = !(detent_hit && press_hit);
        ev1.code    = EVT_PRESS;
        ev1.time_ms = now_reg;
        ev1.last    = 1'b1;
        push_n      = {1'b0, detent_hit} + {1'b0, press_hit};
    end

    // event queue storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            queue_reg[wr_ptr_reg] <= ev0;
        if (push_n == 2'd2)
            queue_reg[wr_ptr_reg + 2'd1] <= ev1;
    end

    // event queue pointers
    assign count_next = count_reg + {1'b0, push_n} - {2'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

    // output beat from queue head
    assign event_code = queue_reg[rd_ptr_reg].code;
    assign event_time = queue_reg[rd_ptr_reg].time_ms;
    assign last       = queue_reg[rd_ptr_reg].last;

`ifndef ASSERT_OFF
    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(QDEPTH))
        else $error("event queue overflow");

    // a non-final beat always has its partner queued behind it
    a_partner_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (count_reg >= 3'd2))
        else $error("non-final event without follower");

    // a detent leaves the accumulator within one detent
    a_detent_rem: assert property (@(posedge clk) disable iff (!rst_n)
        detent_hit |=> (acc_reg < DETENT_POS && acc_reg > DETENT_NEG))
        else $error("accumulator remainder out of range");

    // the processing stage only fires with room for two events
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |=> (count_reg <= 3'(QDEPTH)))
        else $error("processing without queue room");
`endif

endmodule

[sim/rotary_encoder_detent_and_button_test.sv]
// ----------------------------------------------------------------------------
// rotary_encoder_detent_and_button_test - self-checking bench for the encoder
// Drives pin samples and polls through the valid/stall input channel, mirrors
// the step accumulator and button debounce in a local predictor, and checks
// every event beat in order while both channels idle in random bursts.
// ----------------------------------------------------------------------------
module rotary_encoder_detent_and_button_test;
    import rot_enc_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 125;

    // quadrature step for {previous pair, new pair}
    localparam logic signed [7:0] STEP_LUT [16] =
        '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

    typedef struct {
        logic        kind;
        logic        a;
        logic        b;
        logic        btn;
        logic [31:0] ms;
    } enc_item_t;

    typedef struct {
        logic [1:0]  code;
        logic [31:0] stamp;
        logic        last;
    } enc_event_t;

    // dut ports
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [15:0] cfg_wr_data  = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        kind         = KIND_PIN;
    logic        enc_a        = 1'b1;
    logic        enc_b        = 1'b1;
    logic        button_level = 1'b1;
    logic [31:0] now_ms       = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [1:0]  event_code;
    logic [31:0] event_time;
    logic        last;

    // stimulus and expected events
    enc_item_t  pin_poll_q[$];
    enc_event_t expected_events[$];
    enc_item_t  drive_item;
    int         items_queued = 0;

    // predictor state
    logic signed [7:0] detent_count;
    logic [1:0]        last_ab;
    logic              settled_button;
    logic [31:0]       button_stamp;
    logic [15:0]       debounce_setting;

    // generator state
    logic [1:0]  gen_ab  = AB_IDLE;
    logic [31:0] gen_ms  = '0;
    logic        gen_btn = 1'b1;
    logic [31:0] gen_deb = 32'(DEBOUNCE_DEFAULT);

    // bench control and statistics
    logic in_stall_seen = 1'b0;
    logic calm          = 1'b0;
    int   in_gap_left   = 0;
    int   stall_left    = 0;
    int   quiet_cycles  = 0;
    int   n_errors      = 0;
    int   n_pins        = 0;
    int   n_polls       = 0;
    int   n_checked     = 0;
    int   n_cw          = 0;
    int   n_ccw         = 0;
    int   n_press       = 0;
    int   n_settings    = 1;

    rotary_encoder_detent_and_button u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .enc_a        (enc_a),
        .enc_b        (enc_b),
        .button_level (button_level),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_code   (event_code),
        .event_time   (event_time),
        .last         (last)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mirror of the block: accumulate steps, emit detents and debounced presses
    function automatic void predict_events(input enc_item_t it);
        logic [3:0]  idx;
        logic [31:0] age;
        int          v;
        int          rem;
        int          n_new;
        enc_event_t  evs[2];
        begin
            if (it.kind == KIND_PIN)
            begin
                idx = {last_ab, it.a, it.b};
                detent_count = detent_count + STEP_LUT[idx];
                last_ab = {it.a, it.b};
            end
            else
            begin
                n_new = 0;
                v = detent_count;
                if (v >= 4 || v <= -4)
                begin
                    rem = (v < 0 ? -v : v) % 4;
                    if (v < 0)
                        rem = -rem;
                    detent_count = rem[7:0];
                    evs[n_new].code  = (v >= 4) ? EVT_CW : EVT_CCW;
                    evs[n_new].stamp = it.ms;
                    evs[n_new].last  = 1'b0;
                    n_new++;
                end
                if (it.btn != settled_button)
                begin
                    age = it.ms - button_stamp;
                    if (age > {16'd0, debounce_setting})
                    begin
                        settled_button = it.btn;
                        button_stamp = it.ms;
                        if (it.btn == 1'b0)
                        begin
                            evs[n_new].code  = EVT_PRESS;
                            evs[n_new].stamp = it.ms;
                            evs[n_new].last  = 1'b0;
                            n_new++;
                        end
                    end
                end
                else
                    button_stamp = it.ms;
                if (n_new > 0)
                    evs[n_new - 1].last = 1'b1;
                for (int i = 0; i < n_new; i++)
                    expected_events.push_back(evs[i]);
            end
        end
    endfunction

    // compare one output beat with the oldest expected event
    function automatic void check_event();
        enc_event_t e;
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual code %0d time %0h last %0b",
                         $time, event_code, event_time, last);
                n_errors++;
            end
            else
            begin
                e = expected_events.pop_front();
                n_checked++;
                if (event_code !== e.code)
                begin
                    $display("%0t: event_code mismatch, expected %0d, actual %0d",
                             $time, e.code, event_code);
                    n_errors++;
                end
                if (event_time !== e.stamp)
                begin
                    $display("%0t: event_time mismatch, expected %0h, actual %0h",
                             $time, e.stamp, event_time);
                    n_errors++;
                end
                if (last !== e.last)
                begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, e.last, last);
                    n_errors++;
                end
                case (e.code)
                    EVT_CW:  n_cw++;
                    EVT_CCW: n_ccw++;
                    default: n_press++;
                endcase
            end
        end
    endfunction

    // sample handshakes, track the register, predict and check
    always @(posedge clk)
    begin
        in_stall_seen = in_stall;
        if (rst_n)
        begin
            if (cfg_wr_en)
                debounce_setting = cfg_wr_data;
            if (out_valid && !out_stall)
                check_event();
            if (in_valid && !in_stall)
            begin
                predict_events('{kind, enc_a, enc_b, button_level, now_ms});
                if (kind == KIND_PIN)
                    n_pins++;
                else
                    n_polls++;
            end
            // watchdog on cycles with work pending but no beat moving
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (pin_poll_q.size() == 0 && !in_valid && expected_events.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired after %0d cycles without a beat",
                         $time, quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // input driver with random gaps
    always @(negedge clk)
    begin
        if (!(in_valid && in_stall_seen))
        begin
            if (in_gap_left > 0)
            begin
                in_gap_left--;
                in_valid <= 1'b0;
            end
            else if (!calm && pin_poll_q.size() > 0 && $urandom_range(0, 11) == 0)
            begin
                in_gap_left = $urandom_range(0, 17);
                in_valid <= 1'b0;
            end
            else if (pin_poll_q.size() > 0)
            begin
                drive_item = pin_poll_q.pop_front();
                kind         <= drive_item.kind;
                enc_a        <= drive_item.a;
                enc_b        <= drive_item.b;
                button_level <= drive_item.btn;
                now_ms       <= drive_item.ms;
                in_valid     <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 17);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // next pair one step along the gray sequence
    function automatic logic [1:0] next_ab(input logic [1:0] ab, input logic cw);
        logic [1:0] n;
        begin
            if (cw)
                case (ab)
                    2'b11:   n = 2'b01;
                    2'b01:   n = 2'b00;
                    2'b00:   n = 2'b10;
                    default: n = 2'b11;
                endcase
            else
                case (ab)
                    2'b11:   n = 2'b10;
                    2'b10:   n = 2'b00;
                    2'b00:   n = 2'b01;
                    default: n = 2'b11;
                endcase
            return n;
        end
    endfunction

    // time step clustered around the debounce threshold
    function automatic logic [31:0] next_delta();
        logic [31:0] d;
        begin
            case ($urandom_range(0, 7))
                0:       d = gen_deb;
                1:       d = gen_deb + 1;
                2:       d = (gen_deb > 0) ? gen_deb - 1 : 32'd0;
                3:       d = $urandom_range(0, gen_deb);
                4:       d = gen_deb + $urandom_range(2, 200);
                5:       d = $urandom();
                6:       d = 32'd0;
                default: d = $urandom_range(1, 5);
            endcase
            return d;
        end
    endfunction

    task automatic add_pin(input logic a, input logic b);
        begin
            pin_poll_q.push_back('{KIND_PIN, a, b, 1'($urandom_range(0, 1)), $urandom()});
            items_queued++;
            gen_ab = {a, b};
        end
    endtask

    task automatic add_poll_at(input logic btn, input logic [31:0] ms);
        begin
            pin_poll_q.push_back('{KIND_POLL, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), btn, ms});
            items_queued++;
            gen_ms = ms;
        end
    endtask

    task automatic add_poll(input logic btn);
        begin
            add_poll_at(btn, gen_ms + next_delta());
        end
    endtask

    task automatic spin(input logic cw, input int steps);
        logic [1:0] ab;
        begin
            repeat (steps)
            begin
                ab = next_ab(gen_ab, cw);
                add_pin(ab[1], ab[0]);
            end
        end
    endtask

    // wait until all beats are through and the pipeline has emptied
    task automatic wait_idle();
        begin
            while (pin_poll_q.size() != 0 || in_valid || expected_events.size() != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_debounce(input logic [15:0] value);
        begin
            @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= value;
            @(negedge clk);
            cfg_wr_en   <= 1'b0;
            gen_deb = {16'd0, value};
            n_settings++;
        end
    endtask

    // mostly clean rotations and button gestures, with some noise
    task automatic random_phase(input int n_items);
        int   stop_at;
        int   r;
        logic target;
        begin
            stop_at = items_queued + n_items;
            while (items_queued < stop_at)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    spin(1'($urandom_range(0, 1)), $urandom_range(1, 9));
                    if ($urandom_range(0, 3) == 0)
                        spin(1'($urandom_range(0, 1)), $urandom_range(1, 2));
                    add_poll(gen_btn);
                end
                else if (r < 70)
                begin
                    target = ~gen_btn;
                    repeat ($urandom_range(1, 5))
                        add_poll($urandom_range(0, 1) ? target : gen_btn);
                    add_poll(target);
                    gen_btn = target;
                end
                else if (r < 82)
                begin
                    repeat ($urandom_range(1, 4))
                        add_pin(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                else if (r < 95)
                    add_poll_at(1'($urandom_range(0, 1)), $urandom());
                else if (r < 96)
                begin
                    spin(1'($urandom_range(0, 1)), $urandom_range(120, 140));
                    add_poll(gen_btn);
                end
                else
                    add_poll(1'($urandom_range(0, 1)));
            end
        end
    endtask

    logic [15:0] settings [6];

    initial
    begin
        detent_count     = '0;
        last_ab          = AB_IDLE;
        settled_button   = 1'b1;
        button_stamp     = '0;
        debounce_setting = DEBOUNCE_DEFAULT;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: detents both ways, press with detent, threshold, wrap
        add_poll_at(1'b1, 32'd0);
        spin(1'b1, 4);
        add_poll_at(1'b1, 32'd10);
        spin(1'b0, 6);
        add_poll_at(1'b0, 32'd61);
        add_poll_at(1'b1, 32'd111);
        add_poll_at(1'b1, 32'd112);
        add_pin(1'b0, 1'b0);
        add_pin(1'b1, 1'b1);
        add_poll_at(1'b0, 32'hFFFF_FFF0);
        add_poll_at(1'b0, 32'hFFFF_FFFF);
        add_poll_at(1'b1, 32'h0000_0031);
        add_poll_at(1'b1, 32'h0000_0033);
        gen_btn = 1'b1;
        wait_idle();

        settings[0] = 16'd0;
        settings[1] = 16'hFFFF;
        settings[2] = DEBOUNCE_DEFAULT;
        settings[3] = 16'd1;
        settings[4] = 16'($urandom_range(2, 400));
        settings[5] = 16'($urandom());

        for (int p = 0; p < 6; p++)
        begin
            write_debounce(settings[p]);
            if (p == 0)
            begin
                // long spins: land exactly on -128, then wrap past +127
                spin(1'b0, 128 + int'(detent_count));
                add_poll(gen_btn);
                spin(1'b1, 130);
                add_poll(gen_btn);
            end
            if (p == 5)
                calm = 1'b1;
            random_phase(PHASE_ITEMS);
            wait_idle();
        end

        $display("Covered %0d pin samples and %0d polls over %0d debounce settings",
                 n_pins, n_polls, n_settings);
        $display("Checked %0d events: %0d clockwise, %0d counter-clockwise, %0d presses",
                 n_checked, n_cw, n_ccw, n_press);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
hdl/rot_enc_pkg.sv
hdl/rotary_encoder_detent_and_button.sv
sim/rotary_encoder_detent_and_button_test.sv
